// File: sv/eqi_pkg.sv
// ----------------------------------------------------------------------------
// eqi_pkg - shared types and codes of the event queue
// Entry layout, operation codes, status codes and sequencer states.
// ----------------------------------------------------------------------------
package eqi_pkg;

  localparam int MODE_W   = 3;
  localparam int TYPE_W   = 16;
  localparam int ID_W     = 32;
  localparam int BODY_W   = 64;
  localparam int POS_W    = 4;
  localparam int COUNT_W  = 5;
  localparam int STATUS_W = 2;

  localparam logic [MODE_W-1:0] MODE_PUSH   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_POP    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_READ   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_WRITE  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd4;
  localparam logic [MODE_W-1:0] MODE_UNIQUE = 3'd5;

  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd3;

  typedef struct packed {
    logic [TYPE_W-1:0] ev_type;
    logic [ID_W-1:0]   ev_id;
    logic [BODY_W-1:0] ev_body;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_SCAN,
    ST_SHIFT,
    ST_DONE
  } state_t;

endpackage

// File: sv/eqi_in_if.sv
// ----------------------------------------------------------------------------
// eqi_in_if - request channel of the event queue
// Valid/ready channel carrying one operation request.
// ----------------------------------------------------------------------------
interface eqi_in_if;
  logic                           valid;
  logic                           ready;
  logic [eqi_pkg::MODE_W-1:0]     mode;
  logic [eqi_pkg::TYPE_W-1:0]     event_type;
  logic [eqi_pkg::ID_W-1:0]       event_id;
  logic [eqi_pkg::BODY_W-1:0]     event_body;
  logic [eqi_pkg::POS_W-1:0]      position;
  logic                           in_place;

  modport source (output valid, mode, event_type, event_id, event_body, position,
                  in_place, input ready);
  modport sink (input valid, mode, event_type, event_id, event_body, position,
                in_place, output ready);
endinterface

// File: sv/eqi_out_if.sv
// ----------------------------------------------------------------------------
// eqi_out_if - result channel of the event queue
// Valid/ready channel carrying one result per request.
// ----------------------------------------------------------------------------
interface eqi_out_if;
  logic                           valid;
  logic                           ready;
  logic [eqi_pkg::TYPE_W-1:0]     out_type;
  logic [eqi_pkg::ID_W-1:0]       out_id;
  logic [eqi_pkg::BODY_W-1:0]     out_body;
  logic [eqi_pkg::COUNT_W-1:0]    entry_count;
  logic [eqi_pkg::STATUS_W-1:0]   status;

  modport source (output valid, out_type, out_id, out_body, entry_count, status,
                  input ready);
  modport sink (input valid, out_type, out_id, out_body, entry_count, status,
                output ready);
endinterface

// File: sv/eqi_mem.sv
// ----------------------------------------------------------------------------
// eqi_mem - entry storage
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module eqi_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  eqi_pkg::entry_t wdata,
  input  logic [AW-1:0]   raddr,
  output eqi_pkg::entry_t rdata
);

  eqi_pkg::entry_t mem [DEPTH];
  eqi_pkg::entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: sv/eqi_match.sv
// ----------------------------------------------------------------------------
// eqi_match - key compare unit
// Match a stored entry against the search key; a zero key id matches any id.
// ----------------------------------------------------------------------------
module eqi_match (
  input  eqi_pkg::entry_t stored,
  input  eqi_pkg::entry_t key,
  output logic            hit
);

  logic type_eq;
  logic id_eq;

  assign type_eq = (stored.ev_type == key.ev_type);
  assign id_eq   = (key.ev_id == '0) || (stored.ev_id == key.ev_id);
  assign hit     = type_eq && id_eq;

endmodule

// File: sv/event_queue_unique_insert.sv
// ----------------------------------------------------------------------------
// event_queue_unique_insert - ordered event queue with unique insert
// Sequencer, entry count and result register around one entry memory.
// ----------------------------------------------------------------------------
// The queue holds up to QUEUE_DEPTH events in arrival order, head at position
// 0, in a single-port-write, registered-read memory. One request is worked at
// a time; in_chan.ready is high only while the sequencer is idle, and a new
// request is taken even while the previous result still waits on out_chan.
// Push, write, clear, unused modes and requests rejected on entry go from
// idle straight to DONE and the result register. Read passes through FETCH.
// Pop passes through FETCH and SHIFT; unique insert scans in SCAN and, on a
// match that is not in place, also passes through SHIFT: the scan reads one
// entry per cycle through the single compare unit, and removal closes the gap
// by moving one entry per cycle through the memory read and write ports, which
// set this rate. entry_count carries the low 5 bits of the count.
// ----------------------------------------------------------------------------
module event_queue_unique_insert #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  eqi_in_if.sink      in_chan,
  eqi_out_if.source   out_chan
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int PW = (CW > eqi_pkg::POS_W) ? CW : eqi_pkg::POS_W;
  localparam logic [CW-1:0] CNT_FULL = CW'(QUEUE_DEPTH);
  localparam logic [CW-1:0] CNT_ONE  = CW'(1);

  eqi_pkg::state_t state_r, state_nxt;

  // request held for the length of the operation
  logic [eqi_pkg::MODE_W-1:0]   mode_r, mode_nxt;
  eqi_pkg::entry_t              item_r, item_nxt;
  logic                         inplace_r, inplace_nxt;

  // queue count and scan/shift pointers
  logic [CW-1:0]                cnt_r, cnt_nxt;
  logic [CW-1:0]                ridx_r, ridx_nxt;   // next entry to read
  logic [CW-1:0]                cidx_r, cidx_nxt;   // entry now on read data
  logic                         pend_r, pend_nxt;   // read data valid

  // result being built
  eqi_pkg::entry_t              res_r, res_nxt;
  logic [eqi_pkg::STATUS_W-1:0] stat_r, stat_nxt;

  // output register
  logic                         ov_r, ov_nxt;
  eqi_pkg::entry_t              oe_r, oe_nxt;
  logic [eqi_pkg::COUNT_W-1:0]  ocnt_r, ocnt_nxt;
  logic [eqi_pkg::STATUS_W-1:0] ostat_r, ostat_nxt;

  // memory port
  logic                         mem_we;
  logic [AW-1:0]                mem_waddr;
  eqi_pkg::entry_t              mem_wdata;
  logic [AW-1:0]                mem_raddr;
  eqi_pkg::entry_t              mem_rdata;

  eqi_pkg::entry_t              in_item;
  logic                         in_fire;
  logic                         pos_ok;
  logic                         q_full;
  logic                         q_empty;
  logic                         issue;
  logic                         cmp_hit;
  logic                         hit;
  logic                         scan_miss;
  logic                         shift_end;
  logic                         out_load;
  logic [CW-1:0]                shift_dst;
  logic [CW-1:0]                cnt_dec;

  eqi_mem #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  eqi_match u_match (
    .stored (mem_rdata),
    .key    (item_r),
    .hit    (cmp_hit)
  );

  assign in_item.ev_type = in_chan.event_type;
  assign in_item.ev_id   = in_chan.event_id;
  assign in_item.ev_body = in_chan.event_body;

  assign in_chan.ready = (state_r == eqi_pkg::ST_IDLE);
  assign in_fire       = in_chan.valid && in_chan.ready;

  // position compared at a width that holds both the field and the count
  assign pos_ok  = PW'(in_chan.position) < PW'(cnt_r);
  assign q_full  = (cnt_r == CNT_FULL);
  assign q_empty = (cnt_r == '0);

  // one read issued per cycle while entries remain; data shows on the next cycle
  assign issue     = (ridx_r < cnt_r);
  assign hit       = pend_r && cmp_hit;
  assign scan_miss = !hit && !issue;
  assign shift_end = !pend_r && !issue;
  assign out_load  = (state_r == eqi_pkg::ST_DONE) && (!ov_r || out_chan.ready);
  assign shift_dst = cidx_r - CNT_ONE;
  assign cnt_dec   = cnt_r - CNT_ONE;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      eqi_pkg::ST_IDLE: begin
        if (in_fire) begin
          case (in_chan.mode)
            eqi_pkg::MODE_POP:    state_nxt = q_empty ? eqi_pkg::ST_DONE : eqi_pkg::ST_FETCH;
            eqi_pkg::MODE_READ:   state_nxt = pos_ok ? eqi_pkg::ST_FETCH : eqi_pkg::ST_DONE;
            eqi_pkg::MODE_UNIQUE: state_nxt = eqi_pkg::ST_SCAN;
            default:              state_nxt = eqi_pkg::ST_DONE;
          endcase
        end
      end
      eqi_pkg::ST_FETCH: begin
        state_nxt = (mode_r == eqi_pkg::MODE_POP) ? eqi_pkg::ST_SHIFT : eqi_pkg::ST_DONE;
      end
      eqi_pkg::ST_SCAN: begin
        if (hit) begin
          state_nxt = inplace_r ? eqi_pkg::ST_DONE : eqi_pkg::ST_SHIFT;
        end else if (scan_miss) begin
          state_nxt = eqi_pkg::ST_DONE;
        end
      end
      eqi_pkg::ST_SHIFT: begin
        if (shift_end) begin
          state_nxt = eqi_pkg::ST_DONE;
        end
      end
      eqi_pkg::ST_DONE: begin
        if (out_load) begin
          state_nxt = eqi_pkg::ST_IDLE;
        end
      end
      default: state_nxt = eqi_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    mode_nxt    = mode_r;
    item_nxt    = item_r;
    inplace_nxt = inplace_r;
    cnt_nxt     = cnt_r;
    ridx_nxt    = ridx_r;
    cidx_nxt    = cidx_r;
    pend_nxt    = pend_r;
    res_nxt     = res_r;
    stat_nxt    = stat_r;
    mem_we      = 1'b0;
    mem_waddr   = cnt_r[AW-1:0];
    mem_wdata   = item_r;
    mem_raddr   = ridx_r[AW-1:0];

    case (state_r)
      eqi_pkg::ST_IDLE: begin
        // pop reads the head, read its position; the data lands in FETCH
        mem_raddr = (in_chan.mode == eqi_pkg::MODE_POP) ? '0 : AW'(in_chan.position);
        if (in_fire) begin
          mode_nxt    = in_chan.mode;
          item_nxt    = in_item;
          inplace_nxt = in_chan.in_place;
          res_nxt     = '0;
          stat_nxt    = eqi_pkg::STAT_OK;
          ridx_nxt    = '0;
          pend_nxt    = 1'b0;
          mem_wdata   = in_item;
          case (in_chan.mode)
            eqi_pkg::MODE_PUSH: begin
              if (q_full) begin
                stat_nxt = eqi_pkg::STAT_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = cnt_r[AW-1:0];
                cnt_nxt   = cnt_r + CNT_ONE;
              end
            end
            eqi_pkg::MODE_POP: begin
              if (q_empty) begin
                stat_nxt = eqi_pkg::STAT_EMPTY;
              end
            end
            eqi_pkg::MODE_READ: begin
              if (!pos_ok) begin
                stat_nxt = eqi_pkg::STAT_RANGE;
              end
            end
            eqi_pkg::MODE_WRITE: begin
              if (!pos_ok) begin
                stat_nxt = eqi_pkg::STAT_RANGE;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = AW'(in_chan.position);
              end
            end
            eqi_pkg::MODE_CLEAR: begin
              cnt_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      eqi_pkg::ST_FETCH: begin
        res_nxt = mem_rdata;
        // pop: close up from the head
        ridx_nxt = CNT_ONE;
        pend_nxt = 1'b0;
      end
      eqi_pkg::ST_SCAN: begin
        ridx_nxt = issue ? (ridx_r + CNT_ONE) : ridx_r;
        cidx_nxt = ridx_r;
        pend_nxt = issue;
        if (hit) begin
          if (inplace_r) begin
            mem_we    = 1'b1;
            mem_waddr = cidx_r[AW-1:0];
          end else begin
            // drop the match: move everything behind it down by one
            ridx_nxt = cidx_r + CNT_ONE;
            pend_nxt = 1'b0;
          end
        end else if (scan_miss) begin
          if (q_full) begin
            stat_nxt = eqi_pkg::STAT_FULL;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = cnt_r[AW-1:0];
            cnt_nxt   = cnt_r + CNT_ONE;
          end
        end
      end
      eqi_pkg::ST_SHIFT: begin
        ridx_nxt = issue ? (ridx_r + CNT_ONE) : ridx_r;
        cidx_nxt = ridx_r;
        pend_nxt = issue;
        if (pend_r) begin
          mem_we    = 1'b1;
          mem_waddr = shift_dst[AW-1:0];
          mem_wdata = mem_rdata;
        end else if (shift_end) begin
          if (mode_r == eqi_pkg::MODE_UNIQUE) begin
            // append the new event in the freed tail slot
            mem_we    = 1'b1;
            mem_waddr = cnt_dec[AW-1:0];
            mem_wdata = item_r;
          end else begin
            cnt_nxt = cnt_dec;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // output register: load from DONE once the slot is free or being drained
  always_comb begin
    ov_nxt    = ov_r;
    oe_nxt    = oe_r;
    ocnt_nxt  = ocnt_r;
    ostat_nxt = ostat_r;
    if (out_load) begin
      ov_nxt    = 1'b1;
      oe_nxt    = res_r;
      ocnt_nxt  = eqi_pkg::COUNT_W'(cnt_r);
      ostat_nxt = stat_r;
    end else if (out_chan.ready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= eqi_pkg::ST_IDLE;
      cnt_r   <= '0;
      ridx_r  <= '0;
      cidx_r  <= '0;
      pend_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ridx_r  <= ridx_nxt;
      cidx_r  <= cidx_nxt;
      pend_r  <= pend_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r    <= mode_nxt;
    item_r    <= item_nxt;
    inplace_r <= inplace_nxt;
    res_r     <= res_nxt;
    stat_r    <= stat_nxt;
    oe_r      <= oe_nxt;
    ocnt_r    <= ocnt_nxt;
    ostat_r   <= ostat_nxt;
  end

  assign out_chan.valid       = ov_r;
  assign out_chan.out_type    = oe_r.ev_type;
  assign out_chan.out_id      = oe_r.ev_id;
  assign out_chan.out_body    = oe_r.ev_body;
  assign out_chan.entry_count = ocnt_r;
  assign out_chan.status      = ostat_r;

endmodule

// File: sv/eqi_chk.sv
// ----------------------------------------------------------------------------
// eqi_chk - port checker of the event queue
// Checks result consistency and result hold on the top-level ports.
// ----------------------------------------------------------------------------
module eqi_chk #(
  parameter int QUEUE_DEPTH = 16
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [eqi_pkg::TYPE_W-1:0]     out_type,
  input logic [eqi_pkg::ID_W-1:0]       out_id,
  input logic [eqi_pkg::BODY_W-1:0]     out_body,
  input logic [eqi_pkg::COUNT_W-1:0]    entry_count,
  input logic [eqi_pkg::STATUS_W-1:0]   status
);

  localparam logic [eqi_pkg::COUNT_W-1:0] FULL_CNT = eqi_pkg::COUNT_W'(QUEUE_DEPTH);

  // a dropped request reports a full queue
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == eqi_pkg::STAT_FULL) |-> entry_count == FULL_CNT)
    else $error("full status with count below depth");

  // an empty pop reports zero entries
  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == eqi_pkg::STAT_EMPTY) |-> entry_count == '0)
    else $error("empty status with nonzero count");

  // a rejected request returns no entry data
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status != eqi_pkg::STAT_OK) |->
      (out_type == '0) && (out_id == '0) && (out_body == '0))
    else $error("rejected request returned entry data");

  // count never exceeds depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (QUEUE_DEPTH > 31) || (entry_count <= FULL_CNT))
    else $error("count above depth");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status) &&
      $stable(entry_count) && $stable(out_body))
    else $error("stalled result changed");

endmodule

bind event_queue_unique_insert eqi_chk #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_eqi_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .out_type    (out_chan.out_type),
  .out_id      (out_chan.out_id),
  .out_body    (out_chan.out_body),
  .entry_count (out_chan.entry_count),
  .status      (out_chan.status)
);
